FILE: src/lkgt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkgt_pkg: shared types and constants of the k-slot grant table
// Item layouts, action and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lkgt_pkg;

  // field widths fixed by the item layout
  localparam int RANK_W  = 6;
  localparam int CLOCK_W = 31;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;

  // default table depth
  localparam int MAX_NODES_DEF = 64;

  // largest reportable queue position
  localparam int POS_MAX = 63;

  // item actions
  localparam logic [1:0] ACT_ADD_REQ = 2'd0;
  localparam logic [1:0] ACT_REM_REQ = 2'd1;
  localparam logic [1:0] ACT_ADD_ACK = 2'd2;
  localparam logic [1:0] ACT_QUERY   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_RANK       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDED_ACKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFER_HOLDERS = 2'd3;

  // register reset values
  localparam logic [RANK_W-1:0] OWN_RANK_RST    = 6'd0;
  localparam logic [CNT_W-1:0]  NEEDED_ACKS_RST = 7'd64;
  localparam logic [CNT_W-1:0]  SLOT_LIMIT_RST  = 7'd1;

  typedef struct packed {
    logic [1:0]         action;
    logic [RANK_W-1:0]  sender_rank;
    logic [CLOCK_W-1:0] sender_clock;
    logic               holds_other;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [RANK_W-1:0] queue_position;
    logic [CNT_W-1:0]  ack_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OWN,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic upd;     // apply a non-query item and emit its result
    logic own_rd;  // read own request entry, clear scan state
    logic scan;    // issue read of the next table entry
    logic fin;     // decide grant and emit query result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // entry being issued is the last one
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: src/lamport_k_slot_grant_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lamport_k_slot_grant_table: request/ack table with k-slot grant decision
// Keeps one request and one ack entry per sender rank and grants a slot to
// the own request when enough acks are held, all acks are not older than
// the own request and the own request ranks below the slot limit.
//
// Usage:
//   - in channel: an item is taken when start is high and busy is low
//   - out channel: out_valid marks a result for exactly one cycle; the
//     receiver cannot stall, so every result must be taken when shown
//   - cfg port: cfg_we writes cfg_wdata to register cfg_idx (own_rank,
//     needed_acks, slot_limit, prefer_holders); write only while idle
//   - add/remove request and add ack finish in the accept cycle: the result
//     shows in the next cycle and busy stays low, one item per cycle
//   - a query reads the own entry, then scans both tables one entry per
//     cycle through the table RAM read ports, then drains and finishes:
//     busy stays high throughout and falls as the result is shown
//   - reset clears all valid bits, the ack count and the registers to their
//     defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
module lamport_k_slot_grant_table
  import lkgt_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  var  in_item_t             in_item,
  output logic                      out_valid,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  lkgt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_item.action),
    .sts    (sts),
    .busy   (busy),
    .cmd    (cmd)
  );

  // tables and scan datapath
  lkgt_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: src/lkgt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkgt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkgt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: src/lkgt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkgt_ctrl: sequencer of the grant table
// Takes items, runs the table scan for queries and tells the datapath
// when to update, scan and finish.
// ----------------------------------------------------------------------------
module lkgt_ctrl
  import lkgt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] action,
  input  var  ctl_sts_t   sts,
  output logic            busy,
  output ctl_cmd_t        cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_QUERY) begin
            state_nxt = ST_OWN;
          end else begin
            cmd.upd = 1'b1;
          end
        end
      end
      ST_OWN: begin
        cmd.own_rd = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

FILE: src/lkgt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkgt_dp: tables, configuration registers and scan datapath
// Holds the request and ack tables, counts acks, ranks the own request
// over a one-entry-per-cycle scan and forms the result item.
// ----------------------------------------------------------------------------
module lkgt_dp
  import lkgt_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  var  in_item_t             in_item,
  input  var  ctl_cmd_t             cmd,
  output ctl_sts_t                  sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output logic                      out_valid,
  output out_item_t                 out_item
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int REQ_W = CLOCK_W + 1;

  // configuration registers
  logic [RANK_W-1:0] own_rank_r;
  logic [CNT_W-1:0]  needed_acks_r;
  logic [CNT_W-1:0]  slot_limit_r;
  logic              prefer_r;

  // table state
  logic [MAX_NODES-1:0] req_vld_r, req_vld_nxt;
  logic [MAX_NODES-1:0] ack_vld_r, ack_vld_nxt;
  logic [CNT_W-1:0]     ack_cnt_r, ack_cnt_nxt;

  // scan state
  logic [IDX_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               chk_vld_r;
  logic [CLOCK_W-1:0] own_clk_r;
  logic               own_hold_r;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               late_r, late_nxt;

  // result register
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  // ram ports
  logic [IDX_W-1:0]   in_idx;
  logic               rank_ok;
  logic               req_we, ack_we;
  logic [IDX_W-1:0]   req_raddr;
  logic [REQ_W-1:0]   req_rdata;
  logic [CLOCK_W-1:0] ack_rdata;

  // own entry and ranking
  logic [IDX_W-1:0] own_idx;
  logic             own_present;
  logic             ahead;
  logic             grant;

  assign in_idx  = IDX_W'(in_item.sender_rank);
  assign rank_ok = (32'(in_item.sender_rank) < MAX_NODES);
  assign own_idx = IDX_W'(own_rank_r);
  assign own_present = (32'(own_rank_r) < MAX_NODES) && req_vld_r[own_idx];

  assign req_we    = cmd.upd && rank_ok && (in_item.action == ACT_ADD_REQ);
  assign ack_we    = cmd.upd && rank_ok && (in_item.action == ACT_ADD_ACK);
  assign req_raddr = cmd.own_rd ? own_idx : cnt_r;

  // request clock and holder flag per rank
  lkgt_ram #(
    .WIDTH (REQ_W),
    .DEPTH (MAX_NODES)
  ) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (in_idx),
    .wdata ({in_item.holds_other, in_item.sender_clock}),
    .raddr (req_raddr),
    .rdata (req_rdata)
  );

  // ack clock per rank
  lkgt_ram #(
    .WIDTH (CLOCK_W),
    .DEPTH (MAX_NODES)
  ) u_ack_ram (
    .clk   (clk),
    .we    (ack_we),
    .waddr (in_idx),
    .wdata (in_item.sender_clock),
    .raddr (cnt_r),
    .rdata (ack_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r    <= OWN_RANK_RST;
      needed_acks_r <= NEEDED_ACKS_RST;
      slot_limit_r  <= SLOT_LIMIT_RST;
      prefer_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OWN_RANK:       own_rank_r    <= cfg_wdata[RANK_W-1:0];
        REG_NEEDED_ACKS:    needed_acks_r <= cfg_wdata[CNT_W-1:0];
        REG_SLOT_LIMIT:     slot_limit_r  <= cfg_wdata[CNT_W-1:0];
        REG_PREFER_HOLDERS: prefer_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // (holder flag if preferred, clock, rank) order of the scanned entry against the own request
  always_comb begin
    if (prefer_r && (req_rdata[CLOCK_W] != own_hold_r)) begin
      ahead = req_rdata[CLOCK_W];
    end else if (req_rdata[CLOCK_W-1:0] != own_clk_r) begin
      ahead = (req_rdata[CLOCK_W-1:0] < own_clk_r);
    end else begin
      ahead = (chk_idx_r < own_idx);
    end
  end

  // position count and ack lateness check
  always_comb begin
    pos_nxt  = pos_r;
    late_nxt = late_r;
    if (cmd.own_rd) begin
      pos_nxt  = '0;
      late_nxt = 1'b1;
    end else if (chk_vld_r) begin
      if (own_present && (chk_idx_r != own_idx) && req_vld_r[chk_idx_r] && ahead) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (ack_vld_r[chk_idx_r] && (ack_rdata < own_clk_r)) begin
        late_nxt = 1'b0;
      end
    end
  end

  assign grant = (ack_cnt_r >= needed_acks_r) && late_r &&
                 (32'(pos_r) < 32'(slot_limit_r));

  // table updates and result forming
  always_comb begin
    req_vld_nxt  = req_vld_r;
    ack_vld_nxt  = ack_vld_r;
    ack_cnt_nxt  = ack_cnt_r;
    out_item_nxt = out_item_r;
    if (cmd.upd) begin
      if (rank_ok) begin
        case (in_item.action)
          ACT_ADD_REQ: req_vld_nxt[in_idx] = 1'b1;
          ACT_REM_REQ: req_vld_nxt[in_idx] = 1'b0;
          ACT_ADD_ACK: begin
            ack_vld_nxt[in_idx] = 1'b1;
            // count saturates at its widest value
            if (!ack_vld_r[in_idx] && (ack_cnt_r != '1)) begin
              ack_cnt_nxt = ack_cnt_r + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      out_item_nxt.granted        = 1'b0;
      out_item_nxt.queue_position = '0;
      out_item_nxt.ack_count      = ack_cnt_nxt;
    end else if (cmd.fin) begin
      if (grant) begin
        ack_vld_nxt = '0;
        ack_cnt_nxt = '0;
      end
      out_item_nxt.granted        = grant;
      out_item_nxt.queue_position = (32'(pos_r) > POS_MAX) ? RANK_W'(POS_MAX)
                                                           : RANK_W'(pos_r);
      out_item_nxt.ack_count      = ack_cnt_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r   <= '0;
      ack_vld_r   <= '0;
      ack_cnt_r   <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_vld_r   <= req_vld_nxt;
      ack_vld_r   <= ack_vld_nxt;
      ack_cnt_r   <= ack_cnt_nxt;
      chk_vld_r   <= cmd.scan;
      out_valid_r <= cmd.upd || cmd.fin;
      if (cmd.own_rd) begin
        cnt_r <= '0;
      end else if (cmd.scan) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // scan payload registers
  always_ff @(posedge clk) begin
    chk_idx_r  <= cnt_r;
    pos_r      <= pos_nxt;
    late_r     <= late_nxt;
    out_item_r <= out_item_nxt;
    // own entry data arrives during the first scan cycle
    if (cmd.scan && (cnt_r == '0)) begin
      own_clk_r  <= own_present ? req_rdata[CLOCK_W-1:0] : '0;
      own_hold_r <= req_rdata[CLOCK_W];
    end
  end

  assign sts.scan_last = (32'(cnt_r) == MAX_NODES - 1);
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;

endmodule

`default_nettype wire

FILE: src/lkgt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkgt_checker: port-level checks of the grant table
// Watches the item handshake and result strobe over time.
// ----------------------------------------------------------------------------
module lkgt_checker
  import lkgt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input var  in_item_t  in_item,
  input wire logic      out_valid,
  input var  out_item_t out_item
);

  // a result never shows while a query is still running
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // a table update gives a non-granting result in the next cycle
  a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && (in_item.action != ACT_QUERY)) |=>
      (out_valid && !out_item.granted && (out_item.queue_position == '0)))
    else $error("update item result missing or wrong");

  // a query keeps the block busy and holds results back
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy && (in_item.action == ACT_QUERY)) |=>
      (busy && !out_valid))
    else $error("query did not start the scan");

  // a grant empties the ack table
  a_grant_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.granted) |-> (out_item.ack_count == '0))
    else $error("acks left after grant");

endmodule

bind lamport_k_slot_grant_table lkgt_checker u_lkgt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
